### hw/rtl/afeg_pkg.sv
package afeg_pkg;

	localparam int SAMPLE_BITS    = 24;
	localparam int GAIN_FRAC_BITS = 16;
	localparam int MAX_CHANNELS   = 8;

	localparam int GAIN_W   = GAIN_FRAC_BITS + 1;
	localparam int TIME_W   = 64;
	localparam int PERIOD_W = 30;
	localparam int CHAN_W   = 4;
	localparam int CIDX_W   = $clog2(MAX_CHANNELS) > 0 ? $clog2(MAX_CHANNELS) : 1;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH) > 0 ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [GAIN_W-1:0] ONE_Q = GAIN_W'(1) << GAIN_FRAC_BITS;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET   = PERIOD_W'(14700);
	localparam logic [CHAN_W-1:0]   CHANNELS_RESET = CHAN_W'(2);

	localparam logic [CFG_IDX_W-1:0] REG_FADE_IN_ON     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_IN_START  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_IN_END    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_OUT_ON    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_OUT_START = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_OUT_END   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS       = 3'd7;

	typedef struct packed {
		logic                fade_in_on;
		logic [TIME_W-1:0]   fade_in_start;
		logic [TIME_W-1:0]   fade_in_end;
		logic                fade_out_on;
		logic [TIME_W-1:0]   fade_out_start;
		logic [TIME_W-1:0]   fade_out_end;
		logic [PERIOD_W-1:0] frame_period;
		logic [CHAN_W-1:0]   channels;
	} cfg_t;

	// one classified sample on its way from front to back
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          failed;
		logic                          need_gain;
		logic [TIME_W-1:0]             frame_time;
	} item_t;

endpackage

### hw/rtl/audio_fade_envelope_gain_core.sv
// A sample that reuses the frame gain passes from the queue through ST_IDLE and ST_EMIT
//   to the result register; the first sample of a frame computes a new envelope gain
//   through ST_IN, ST_DIV_IN, ST_OUT, ST_DIV_OUT and ST_GMUL before ST_EMIT.
// The back takes a new sample only once it is back in ST_IDLE; the 16-step restoring
//   divider runs once per active fade window.
// Reset (arst_n low, asynchronous): both queues empty, frame time, channel count and
//   frame gain cleared, registers at defaults (frame period 14700, two channels).
module audio_fade_envelope_gain_core (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// configuration writes, taken whenever cfg_we is high
	input  logic                                    cfg_we,
	input  logic [afeg_pkg::CFG_IDX_W-1:0]          cfg_idx,
	input  logic [afeg_pkg::CFG_DATA_W-1:0]         cfg_wdata,
	// sample input, queue style
	input  logic                                    push,
	output logic                                    full,
	input  logic signed [afeg_pkg::SAMPLE_BITS-1:0] sample_in,
	input  logic                                    block_first,
	input  logic signed [afeg_pkg::TIME_W-1:0]      block_time,
	input  logic                                    upstream_failed,
	// result output, queue style
	output logic                                    empty,
	input  logic                                    pop,
	output logic signed [afeg_pkg::SAMPLE_BITS-1:0] sample_out,
	output logic [afeg_pkg::GAIN_W-1:0]             gain_used
);

	afeg_pkg::cfg_t  cfg_q;
	afeg_pkg::item_t fq_wr_data;
	afeg_pkg::item_t fq_rd_data;
	logic            fq_wr;
	logic            fq_full;
	logic            fq_rd;
	logic            fq_empty;

	// Register file. The user must change values only while the datapath is idle (the block
	// does not enforce this), so the front and back read them straight from here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fade_in_on     <= 1'b0;
			cfg_q.fade_in_start  <= '0;
			cfg_q.fade_in_end    <= '0;
			cfg_q.fade_out_on    <= 1'b0;
			cfg_q.fade_out_start <= '0;
			cfg_q.fade_out_end   <= '0;
			cfg_q.frame_period   <= afeg_pkg::PERIOD_RESET;
			cfg_q.channels       <= afeg_pkg::CHANNELS_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				afeg_pkg::REG_FADE_IN_ON:     cfg_q.fade_in_on     <= cfg_wdata[0];
				afeg_pkg::REG_FADE_IN_START:  cfg_q.fade_in_start  <= cfg_wdata;
				afeg_pkg::REG_FADE_IN_END:    cfg_q.fade_in_end    <= cfg_wdata;
				afeg_pkg::REG_FADE_OUT_ON:    cfg_q.fade_out_on    <= cfg_wdata[0];
				afeg_pkg::REG_FADE_OUT_START: cfg_q.fade_out_start <= cfg_wdata;
				afeg_pkg::REG_FADE_OUT_END:   cfg_q.fade_out_end   <= cfg_wdata;
				afeg_pkg::REG_FRAME_PERIOD: begin
					cfg_q.frame_period <= cfg_wdata[afeg_pkg::PERIOD_W-1:0];
				end
				afeg_pkg::REG_CHANNELS: begin
					cfg_q.channels <= cfg_wdata[afeg_pkg::CHAN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Front: tracks frame time and channel position, tags each transaction with
	// the time of its frame and whether it opens a frame (needs a fresh gain).
	afeg_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.push            (push),
		.full            (full),
		.sample_in       (sample_in),
		.block_first     (block_first),
		.block_time      (block_time),
		.upstream_failed (upstream_failed),
		.q_full          (fq_full),
		.q_wr            (fq_wr),
		.q_data          (fq_wr_data)
	);

	// Short queue so the front keeps counting while the back sits in a divide.
	afeg_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fq_wr),
		.wr_data (fq_wr_data),
		.full    (fq_full),
		.rd_en   (fq_rd),
		.rd_data (fq_rd_data),
		.empty   (fq_empty)
	);

	// Back: envelope gain (two ramp divides and a product), sample scaling and
	// the result register that faces the consumer.
	afeg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_empty    (fq_empty),
		.q_data     (fq_rd_data),
		.q_rd       (fq_rd),
		.pop        (pop),
		.empty      (empty),
		.sample_out (sample_out),
		.gain_used  (gain_used)
	);

endmodule

### hw/rtl/afeg_fifo.sv
module afeg_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  afeg_pkg::item_t wr_data,
	output logic            full,
	input  logic            rd_en,
	output afeg_pkg::item_t rd_data,
	output logic            empty
);

	afeg_pkg::item_t                  entries_q [afeg_pkg::QUEUE_DEPTH];
	logic [afeg_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [afeg_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [afeg_pkg::QCNT_W-1:0]      count_q;
	logic                             do_wr;
	logic                             do_rd;

	assign full    = (count_q == afeg_pkg::QCNT_W'(afeg_pkg::QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				if (wr_ptr_q == afeg_pkg::QPTR_W'(afeg_pkg::QUEUE_DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (do_rd) begin
				if (rd_ptr_q == afeg_pkg::QPTR_W'(afeg_pkg::QUEUE_DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/afeg_front.sv
module afeg_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  afeg_pkg::cfg_t                       cfg,
	input  logic                                 push,
	output logic                                 full,
	input  logic signed [afeg_pkg::SAMPLE_BITS-1:0] sample_in,
	input  logic                                 block_first,
	input  logic [afeg_pkg::TIME_W-1:0]          block_time,
	input  logic                                 upstream_failed,
	input  logic                                 q_full,
	output logic                                 q_wr,
	output afeg_pkg::item_t                      q_data
);

	logic [afeg_pkg::TIME_W-1:0] time_q;
	logic [afeg_pkg::CIDX_W-1:0] cidx_q;
	logic [afeg_pkg::TIME_W-1:0] time_cur;
	logic [afeg_pkg::CIDX_W-1:0] cidx_cur;
	logic [afeg_pkg::CHAN_W-1:0] ch_eff;
	logic [afeg_pkg::CHAN_W:0]   cidx_inc;
	logic                        frame_end;

	assign full = q_full;
	assign q_wr = push && !q_full;

	always_comb begin
		if (cfg.channels == '0) begin
			ch_eff = afeg_pkg::CHAN_W'(1);
		end else if (cfg.channels > afeg_pkg::CHAN_W'(afeg_pkg::MAX_CHANNELS)) begin
			ch_eff = afeg_pkg::CHAN_W'(afeg_pkg::MAX_CHANNELS);
		end else begin
			ch_eff = cfg.channels;
		end
	end

	assign time_cur  = block_first ? block_time : time_q;
	assign cidx_cur  = block_first ? '0 : cidx_q;
	assign cidx_inc  = (afeg_pkg::CHAN_W + 1)'(cidx_cur) + 1'b1;
	assign frame_end = (cidx_inc >= {1'b0, ch_eff});

	always_comb begin
		q_data.sample     = sample_in;
		q_data.failed     = upstream_failed;
		q_data.need_gain  = (cidx_cur == '0);
		q_data.frame_time = time_cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
			cidx_q <= '0;
		end else if (q_wr) begin
			if (frame_end) begin
				cidx_q <= '0;
				time_q <= time_cur + afeg_pkg::TIME_W'(cfg.frame_period);
			end else begin
				cidx_q <= cidx_inc[afeg_pkg::CIDX_W-1:0];
				time_q <= time_cur;
			end
		end
	end

endmodule

### hw/rtl/afeg_back.sv
module afeg_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  afeg_pkg::cfg_t                        cfg,
	input  logic                                  q_empty,
	input  afeg_pkg::item_t                       q_data,
	output logic                                  q_rd,
	input  logic                                  pop,
	output logic                                  empty,
	output logic signed [afeg_pkg::SAMPLE_BITS-1:0] sample_out,
	output logic [afeg_pkg::GAIN_W-1:0]           gain_used
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_IN      = 3'd1;
	localparam logic [2:0] ST_DIV_IN  = 3'd2;
	localparam logic [2:0] ST_OUT     = 3'd3;
	localparam logic [2:0] ST_DIV_OUT = 3'd4;
	localparam logic [2:0] ST_GMUL    = 3'd5;
	localparam logic [2:0] ST_EMIT    = 3'd6;

	localparam int CNT_W  = $clog2(afeg_pkg::GAIN_FRAC_BITS);
	localparam int GPROD_W = 2 * afeg_pkg::GAIN_W;
	localparam int SPROD_W = afeg_pkg::SAMPLE_BITS + afeg_pkg::GAIN_W + 1;

	logic [2:0]                             state_q;
	logic signed [afeg_pkg::SAMPLE_BITS-1:0] cur_sample_q;
	logic                                   cur_failed_q;
	logic [afeg_pkg::TIME_W-1:0]            cur_time_q;
	logic [afeg_pkg::GAIN_W-1:0]            gin_q;
	logic [afeg_pkg::GAIN_W-1:0]            gout_q;
	logic [afeg_pkg::GAIN_W-1:0]            gain_q;
	logic [afeg_pkg::TIME_W-1:0]            num_q;
	logic [afeg_pkg::TIME_W-1:0]            den_q;
	logic [afeg_pkg::GAIN_FRAC_BITS-1:0]    quo_q;
	logic [CNT_W-1:0]                       cnt_q;
	logic                                   res_valid_q;
	logic signed [afeg_pkg::SAMPLE_BITS-1:0] res_sample_q;
	logic [afeg_pkg::GAIN_W-1:0]            res_gain_q;

	logic                                   win_on;
	logic [afeg_pkg::TIME_W-1:0]            win_start;
	logic [afeg_pkg::TIME_W-1:0]            win_end;
	logic                                   lt_start;
	logic                                   lt_end;
	logic [afeg_pkg::TIME_W:0]              rem_shift;
	logic [afeg_pkg::TIME_W:0]              rem_sub;
	logic                                   rem_ge;
	logic [afeg_pkg::TIME_W-1:0]            num_next;
	logic [afeg_pkg::GAIN_FRAC_BITS-1:0]    quo_next;
	logic                                   div_last;
	logic [GPROD_W-1:0]                     gprod;
	logic signed [SPROD_W-1:0]              sprod;
	logic                                   emit_ok;

	// one comparator pair shared by the fade-in and fade-out windows
	assign win_on    = (state_q == ST_OUT) ? cfg.fade_out_on : cfg.fade_in_on;
	assign win_start = (state_q == ST_OUT) ? cfg.fade_out_start : cfg.fade_in_start;
	assign win_end   = (state_q == ST_OUT) ? cfg.fade_out_end : cfg.fade_in_end;
	assign lt_start  = $signed(cur_time_q) < $signed(win_start);
	assign lt_end    = $signed(cur_time_q) < $signed(win_end);

	// restoring divide, one quotient bit per cycle
	assign rem_shift = {num_q, 1'b0};
	assign rem_sub   = rem_shift - {1'b0, den_q};
	assign rem_ge    = rem_shift >= {1'b0, den_q};
	assign num_next  = rem_ge ? rem_sub[afeg_pkg::TIME_W-1:0] : rem_shift[afeg_pkg::TIME_W-1:0];
	assign quo_next  = {quo_q[afeg_pkg::GAIN_FRAC_BITS-2:0], rem_ge};
	assign div_last  = (cnt_q == CNT_W'(afeg_pkg::GAIN_FRAC_BITS - 1));

	assign gprod = GPROD_W'(gin_q) * GPROD_W'(gout_q);
	assign sprod = SPROD_W'(cur_sample_q) * SPROD_W'($signed({1'b0, gain_q}));

	assign q_rd    = (state_q == ST_IDLE) && !q_empty;
	assign emit_ok = (state_q == ST_EMIT) && (!res_valid_q || pop);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cur_sample_q <= q_data.sample;
				cur_failed_q <= q_data.failed;
				cur_time_q   <= q_data.frame_time;
			end
			ST_IN, ST_OUT: begin
				num_q <= cur_time_q - win_start;
				den_q <= win_end - win_start;
				quo_q <= '0;
				cnt_q <= '0;
			end
			ST_DIV_IN, ST_DIV_OUT: begin
				num_q <= num_next;
				quo_q <= quo_next;
				cnt_q <= cnt_q + 1'b1;
			end
			default: begin
			end
		endcase
		if (state_q == ST_IN) begin
			if (!win_on) begin
				gin_q <= afeg_pkg::ONE_Q;
			end else if (lt_start) begin
				gin_q <= '0;
			end else begin
				gin_q <= afeg_pkg::ONE_Q;
			end
		end else if (state_q == ST_DIV_IN && div_last) begin
			gin_q <= afeg_pkg::GAIN_W'(quo_next);
		end
		if (state_q == ST_OUT) begin
			if (!win_on || lt_start) begin
				gout_q <= afeg_pkg::ONE_Q;
			end else begin
				gout_q <= '0;
			end
		end else if (state_q == ST_DIV_OUT && div_last) begin
			gout_q <= afeg_pkg::ONE_Q - afeg_pkg::GAIN_W'(quo_next);
		end
		if (emit_ok) begin
			if (cur_failed_q) begin
				res_sample_q <= '0;
				res_gain_q   <= '0;
			end else begin
				res_sample_q <= sprod[afeg_pkg::GAIN_FRAC_BITS +: afeg_pkg::SAMPLE_BITS];
				res_gain_q   <= gain_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			gain_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= q_data.need_gain ? ST_IN : ST_EMIT;
					end
				end
				ST_IN: begin
					if (win_on && !lt_start && lt_end) begin
						state_q <= ST_DIV_IN;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_DIV_IN: begin
					if (div_last) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (win_on && !lt_start && lt_end) begin
						state_q <= ST_DIV_OUT;
					end else begin
						state_q <= ST_GMUL;
					end
				end
				ST_DIV_OUT: begin
					if (div_last) begin
						state_q <= ST_GMUL;
					end
				end
				ST_GMUL: begin
					gain_q  <= gprod[afeg_pkg::GAIN_FRAC_BITS +: afeg_pkg::GAIN_W];
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (emit_ok) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign empty      = !res_valid_q;
	assign sample_out = res_sample_q;
	assign gain_used  = res_gain_q;

endmodule

### hw/rtl/afeg_checker.sv
module afeg_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    push,
	input logic                                    full,
	input logic                                    empty,
	input logic                                    pop,
	input logic signed [afeg_pkg::SAMPLE_BITS-1:0] sample_out,
	input logic [afeg_pkg::GAIN_W-1:0]             gain_used
);

	logic [2:0] pending_q;
	logic       push_ok;
	logic       pop_ok;

	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (push_ok && !pop_ok) begin
			pending_q <= pending_q + 1'b1;
		end else if (pop_ok && !push_ok) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	// no result shows up without a transaction that caused it
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> pending_q != '0)
		else $error("result shown with no transaction outstanding");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> gain_used <= afeg_pkg::ONE_Q)
		else $error("gain above unity");

	a_zero_gain_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && gain_used == '0) |-> sample_out == '0)
		else $error("nonzero sample with zero gain");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(sample_out) && $stable(gain_used)))
		else $error("waiting result changed or vanished");

endmodule

bind audio_fade_envelope_gain_core afeg_checker u_afeg_checker (.*);
